>>> hdl/sfs_pkg.sv
// Shared types and constants for the sprite frame sequencer.
// No dependencies; compiled first.
`timescale 1ns / 1ps
`default_nettype none

package sfs_pkg;

  localparam int ACC_W = 24;
  localparam int POS_W = 9;
  localparam int LEN_W = 10;
  localparam int CFG_W = 20;
  localparam int CIDX_W = 3;

  typedef enum logic [2:0] {
    CMD_TICK   = 3'd0,
    CMD_START  = 3'd1,
    CMD_STOP   = 3'd2,
    CMD_PAUSE  = 3'd3,
    CMD_RESUME = 3'd4,
    CMD_LOAD   = 3'd5
  } cmd_t;

  localparam logic [1:0] MODE_FWD    = 2'd0;
  localparam logic [1:0] MODE_PING   = 2'd1;
  localparam logic [1:0] MODE_CUSTOM = 2'd2;

  localparam logic [CIDX_W-1:0] CFG_LIST_MODE    = 3'd0;
  localparam logic [CIDX_W-1:0] CFG_LOOP_ENABLE  = 3'd1;
  localparam logic [CIDX_W-1:0] CFG_RANGE_START  = 3'd2;
  localparam logic [CIDX_W-1:0] CFG_RANGE_END    = 3'd3;
  localparam logic [CIDX_W-1:0] CFG_FRAME_PERIOD = 3'd4;
  localparam logic [CIDX_W-1:0] CFG_CUSTOM_LEN   = 3'd5;

  typedef struct packed {
    logic [2:0]  cmd;
    logic [19:0] elapsed_us;
    logic [5:0]  entry_index;
    logic [7:0]  entry_frame;
  } sfs_in_t;

  typedef struct packed {
    logic [7:0] frame_number;
    logic [8:0] play_position;
    logic       playing;
    logic       advanced;
  } sfs_out_t;

endpackage

`default_nettype wire

>>> hdl/sfs_chan_if.sv
// Valid/ready request channel with a typed payload.
// Payload types come from sfs_pkg at instantiation.
`timescale 1ns / 1ps
`default_nettype none

interface sfs_chan_if #(parameter type payload_t = logic);
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

>>> hdl/sprite_frame_sequencer_unit.sv
// Sprite frame sequencer top level: command decode, play state, frame table.
// Depends on sfs_pkg and sfs_chan_if.
`timescale 1ns / 1ps
`default_nettype none

// One request is accepted per clock and its result appears in the output
// register on the next clock, so the block sustains one request per cycle.
// The only limit is the single output register: a request is taken whenever
// that register is empty or its result is being taken in the same cycle.
// The custom frame table is read once per request with registered read data
// that forms part of the output register; a table write and a read of the
// same slot in one request return the newly written frame. Table entries
// reset to zero through per-entry valid bits, so no clearing pass is needed.
// Configuration writes take effect on the next clock.
module sprite_frame_sequencer_unit #(
  parameter int TABLE_DEPTH = 64,
  parameter int FRAME_BITS  = 8
) (
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  sfs_chan_if.sink                     in_req,
  sfs_chan_if.source                   out_res,
  input  wire logic                    cfg_we,
  input  wire logic [sfs_pkg::CIDX_W-1:0] cfg_index,
  input  wire logic [sfs_pkg::CFG_W-1:0]  cfg_wdata
);
  import sfs_pkg::*;

  localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int FW = (FRAME_BITS < 8) ? FRAME_BITS : 8;
  localparam logic [7:0] FMASK = 8'((1 << FW) - 1);

  // configuration
  logic [1:0]       list_mode_r;
  logic             loop_en_r;
  logic [7:0]       range_start_r;
  logic [7:0]       range_end_r;
  logic [19:0]      period_r;
  logic [6:0]       custom_len_r;

  // play state
  logic [ACC_W-1:0] acc_r, acc_nxt;
  logic [POS_W-1:0] pos_r, pos_nxt;
  logic             run_r, run_nxt;

  // frame table
  logic [FW-1:0]          tbl_mem [TABLE_DEPTH];
  logic [TABLE_DEPTH-1:0] tbl_vld_r;
  logic [FW-1:0]          tbl_rd_r;

  // result register
  logic             out_valid_r;
  logic [7:0]       res_frame_r;
  logic             res_custom_r;
  logic [POS_W-1:0] res_pos_r;
  logic             res_playing_r;
  logic             res_adv_r;

  logic             in_acc;
  cmd_t             cmd;
  logic [7:0]       rng_end;
  logic [LEN_W-1:0] rng_cnt;
  logic [LEN_W-1:0] cust_len;
  logic [LEN_W-1:0] list_len;
  logic [ACC_W:0]   acc_sum;
  logic [ACC_W-1:0] acc_sat;
  logic             step;
  logic [LEN_W-1:0] pos_inc;
  logic [LEN_W-1:0] pc;
  logic [7:0]       rng_frame;
  logic             tbl_we;
  logic [AW-1:0]    tbl_waddr;
  logic [AW-1:0]    tbl_raddr;
  sfs_out_t         res;

  assign in_req.ready = !out_valid_r || out_res.ready;
  assign in_acc       = in_req.valid && in_req.ready;
  assign cmd          = cmd_t'(in_req.data.cmd);

  always_comb begin
    rng_end = (range_end_r < range_start_r) ? range_start_r : range_end_r;
    rng_cnt = LEN_W'(rng_end) - LEN_W'(range_start_r) + LEN_W'(1);
    if (custom_len_r == '0) begin
      cust_len = LEN_W'(1);
    end else if (32'(custom_len_r) > TABLE_DEPTH) begin
      cust_len = LEN_W'(TABLE_DEPTH);
    end else begin
      cust_len = LEN_W'(custom_len_r);
    end
    case (list_mode_r)
      MODE_CUSTOM: list_len = cust_len;
      MODE_PING: begin
        if (loop_en_r) begin
          list_len = (rng_cnt > LEN_W'(1)) ? (rng_cnt << 1) - LEN_W'(2) : LEN_W'(1);
        end else begin
          list_len = (rng_cnt << 1) - LEN_W'(1);
        end
      end
      default: list_len = rng_cnt;
    endcase
  end

  always_comb begin
    acc_sum = {1'b0, acc_r} + (ACC_W + 1)'(in_req.data.elapsed_us);
    acc_sat = acc_sum[ACC_W] ? '1 : acc_sum[ACC_W-1:0];
    step    = acc_sat >= ACC_W'(period_r);
    pos_inc = LEN_W'(pos_r) + LEN_W'(1);
    acc_nxt = acc_r;
    pos_nxt = pos_r;
    run_nxt = run_r;
    case (cmd)
      CMD_TICK: begin
        if (run_r) begin
          acc_nxt = step ? acc_sat - ACC_W'(period_r) : acc_sat;
          if (step) begin
            if (pos_inc >= list_len) begin
              if (loop_en_r) begin
                pos_nxt = '0;
              end else begin
                pos_nxt = POS_W'(list_len - LEN_W'(1));
                run_nxt = 1'b0;
              end
            end else begin
              pos_nxt = pos_inc[POS_W-1:0];
            end
          end
        end
      end
      CMD_START: begin
        run_nxt = 1'b1;
        pos_nxt = '0;
      end
      CMD_STOP: begin
        run_nxt = 1'b0;
        pos_nxt = '0;
      end
      CMD_PAUSE:  run_nxt = 1'b0;
      CMD_RESUME: run_nxt = 1'b1;
      default: ;
    endcase
  end

  // frame lookup at the updated position, clamped to the list end
  always_comb begin
    pc = (LEN_W'(pos_nxt) >= list_len) ? list_len - LEN_W'(1) : LEN_W'(pos_nxt);
    if (list_mode_r == MODE_PING && pc >= rng_cnt) begin
      rng_frame = range_start_r + 8'((rng_cnt - LEN_W'(1)) << 1) - pc[7:0];
    end else begin
      rng_frame = range_start_r + pc[7:0];
    end
    rng_frame = rng_frame & FMASK;
    tbl_raddr = AW'(pc);
    tbl_waddr = AW'(in_req.data.entry_index);
    tbl_we    = in_acc && cmd == CMD_LOAD
                && 32'(in_req.data.entry_index) < TABLE_DEPTH;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      list_mode_r   <= MODE_FWD;
      loop_en_r     <= 1'b0;
      range_start_r <= '0;
      range_end_r   <= '0;
      period_r      <= 20'd1;
      custom_len_r  <= 7'd1;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_LIST_MODE:    list_mode_r   <= cfg_wdata[1:0];
        CFG_LOOP_ENABLE:  loop_en_r     <= cfg_wdata[0];
        CFG_RANGE_START:  range_start_r <= cfg_wdata[7:0];
        CFG_RANGE_END:    range_end_r   <= cfg_wdata[7:0];
        CFG_FRAME_PERIOD: period_r      <= cfg_wdata[19:0];
        CFG_CUSTOM_LEN:   custom_len_r  <= cfg_wdata[6:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r       <= '0;
      pos_r       <= '0;
      run_r       <= 1'b0;
      tbl_vld_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_acc) begin
        acc_r <= acc_nxt;
        pos_r <= pos_nxt;
        run_r <= run_nxt;
      end
      if (tbl_we) begin
        tbl_vld_r[tbl_waddr] <= 1'b1;
      end
      if (in_acc) begin
        out_valid_r <= 1'b1;
      end else if (out_res.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (tbl_we) begin
      tbl_mem[tbl_waddr] <= in_req.data.entry_frame[FW-1:0];
    end
  end

  // read port; a same-request write to the read slot is forwarded
  always_ff @(posedge clk) begin
    if (in_acc) begin
      if (tbl_we && tbl_waddr == tbl_raddr) begin
        tbl_rd_r <= in_req.data.entry_frame[FW-1:0];
      end else if (tbl_vld_r[tbl_raddr]) begin
        tbl_rd_r <= tbl_mem[tbl_raddr];
      end else begin
        tbl_rd_r <= '0;
      end
      res_frame_r   <= rng_frame;
      res_custom_r  <= list_mode_r == MODE_CUSTOM;
      res_pos_r     <= pos_nxt;
      res_playing_r <= run_nxt;
      res_adv_r     <= pos_nxt != pos_r;
    end
  end

  always_comb begin
    res.frame_number  = res_custom_r ? 8'(tbl_rd_r) : res_frame_r;
    res.play_position = res_pos_r;
    res.playing       = res_playing_r;
    res.advanced      = res_adv_r;
  end

  assign out_res.valid = out_valid_r;
  assign out_res.data  = res;

  // the pending result always reflects the live play state
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (res_pos_r == pos_r && res_playing_r == run_r))
    else $error("result register out of step with play state");

  assert property (@(posedge clk) disable iff (!rst_n)
    pos_r != '1)
    else $error("play position beyond longest list");

  assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && cmd == CMD_TICK && !run_r) |=> ($stable(acc_r) && $stable(pos_r)))
    else $error("tick while stopped changed play state");

  assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && (cmd == CMD_START || cmd == CMD_STOP)) |=> (pos_r == '0))
    else $error("start or stop did not rewind position");

endmodule

`default_nettype wire

>>> sim/sprite_frame_sequencer_unit_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for sprite_frame_sequencer_unit: directed and random
// command streams under random idling, checked against a play-state predictor.
// Depends on sfs_pkg, sfs_chan_if and the sequencer RTL.

module sprite_frame_sequencer_unit_tb;
  import sfs_pkg::*;

  localparam int TBL_DEPTH = 64;
  localparam logic [23:0] ACC_SAT = 24'hFFFFFF;
  localparam logic [19:0] ELAPSED_MAX = 20'hFFFFF;
  localparam logic [2:0] CMD_NOP_LO = 3'd6;
  localparam logic [2:0] CMD_NOP_HI = 3'd7;
  localparam logic [1:0] MODE_FWD_ALIAS = 2'd3;
  localparam int TARGET_REQS = 1250;
  localparam int CYCLE_LIMIT = 400000;

  class frame_seq_scoreboard;
    logic [1:0]  mode;
    logic        loop_en;
    logic [7:0]  rng_start;
    logic [7:0]  rng_end;
    logic [19:0] period;
    logic [6:0]  custom_len;
    logic [23:0] acc;
    logic [8:0]  pos;
    logic        run;
    logic [7:0]  frame_tbl [TBL_DEPTH];
    sfs_out_t    expected_frames [$];
    int          errors;
    int          checked;

    function new();
      mode = MODE_FWD;
      loop_en = 1'b0;
      rng_start = '0;
      rng_end = '0;
      period = 20'd1;
      custom_len = 7'd1;
      acc = '0;
      pos = '0;
      run = 1'b0;
      foreach (frame_tbl[i]) frame_tbl[i] = '0;
      errors = 0;
      checked = 0;
    endfunction

    function void write_reg(logic [CIDX_W-1:0] idx, logic [CFG_W-1:0] val);
      case (idx)
        CFG_LIST_MODE:    mode = val[1:0];
        CFG_LOOP_ENABLE:  loop_en = val[0];
        CFG_RANGE_START:  rng_start = val[7:0];
        CFG_RANGE_END:    rng_end = val[7:0];
        CFG_FRAME_PERIOD: period = val[19:0];
        CFG_CUSTOM_LEN:   custom_len = val[6:0];
        default: ;
      endcase
    endfunction

    function int unsigned range_count();
      int unsigned top;
      top = (rng_end < rng_start) ? rng_start : rng_end;
      return top - rng_start + 1;
    endfunction

    function int unsigned list_len();
      int unsigned n;
      if (mode == MODE_CUSTOM) begin
        n = custom_len;
        if (n == 0) n = 1;
        if (n > TBL_DEPTH) n = TBL_DEPTH;
        return n;
      end
      n = range_count();
      if (mode == MODE_PING) begin
        if (loop_en) return (n > 1) ? 2 * n - 2 : 1;
        return 2 * n - 1;
      end
      return n;
    endfunction

    function logic [7:0] frame_at(int unsigned p);
      int unsigned len;
      int unsigned n;
      len = list_len();
      if (p >= len) p = len - 1;
      if (mode == MODE_CUSTOM) return frame_tbl[p];
      n = range_count();
      if (mode == MODE_PING && p >= n) return 8'(rng_start + 2 * (n - 1) - p);
      return 8'(rng_start + p);
    endfunction

    function void accept_command(sfs_in_t req);
      logic [8:0]  old_pos;
      int unsigned sum;
      int unsigned len;
      int unsigned next_pos;
      sfs_out_t    res;
      old_pos = pos;
      case (req.cmd)
        CMD_TICK: begin
          if (run) begin
            sum = acc + req.elapsed_us;
            acc = (sum > ACC_SAT) ? ACC_SAT : 24'(sum);
            if (acc >= period) begin
              len = list_len();
              acc = acc - period;
              next_pos = pos + 1;
              if (next_pos >= len) begin
                if (loop_en) begin
                  next_pos = 0;
                end else begin
                  next_pos = len - 1;
                  run = 1'b0;
                end
              end
              pos = 9'(next_pos);
            end
          end
        end
        CMD_START: begin
          run = 1'b1;
          pos = '0;
        end
        CMD_STOP: begin
          run = 1'b0;
          pos = '0;
        end
        CMD_PAUSE:  run = 1'b0;
        CMD_RESUME: run = 1'b1;
        CMD_LOAD:   frame_tbl[req.entry_index] = req.entry_frame;
        default: ;
      endcase
      res.frame_number = frame_at(pos);
      res.play_position = pos;
      res.playing = run;
      res.advanced = (pos != old_pos);
      expected_frames = {expected_frames, res};
    endfunction

    task report_mismatch(string field, int got_v, int want_v);
      errors++;
      $display("mismatch at result %0d: %s got %0d expected %0d",
               checked, field, got_v, want_v);
    endtask

    task check_result(sfs_out_t got);
      sfs_out_t want;
      checked++;
      if (expected_frames.size() == 0) begin
        report_mismatch("result with no request pending", int'(got), 0);
        return;
      end
      want = expected_frames.pop_front();
      if (got.frame_number !== want.frame_number)
        report_mismatch("frame_number", got.frame_number, want.frame_number);
      if (got.play_position !== want.play_position)
        report_mismatch("play_position", got.play_position, want.play_position);
      if (got.playing !== want.playing)
        report_mismatch("playing", got.playing, want.playing);
      if (got.advanced !== want.advanced)
        report_mismatch("advanced", got.advanced, want.advanced);
    endtask
  endclass

  logic clk = 1'b0;
  logic rst_n;
  logic cfg_we;
  logic [CIDX_W-1:0] cfg_index;
  logic [CFG_W-1:0] cfg_wdata;

  sfs_chan_if #(.payload_t(sfs_in_t)) req_ch ();
  sfs_chan_if #(.payload_t(sfs_out_t)) res_ch ();

  frame_seq_scoreboard sb;
  sfs_in_t batch [$];
  logic [19:0] cur_period = 20'd1;
  bit burst = 1'b0;
  int cycles = 0;
  int sent = 0;

  sprite_frame_sequencer_unit #(.TABLE_DEPTH(TBL_DEPTH), .FRAME_BITS(8)) uut (
    .clk(clk),
    .rst_n(rst_n),
    .in_req(req_ch),
    .out_res(res_ch),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("FAIL sprite_frame_sequencer_unit");
      $finish;
    end
  end

  function automatic void push_req(logic [2:0] cmd, logic [19:0] el, logic [5:0] idx,
                                   logic [7:0] fr);
    sfs_in_t r;
    r.cmd = cmd;
    r.elapsed_us = el;
    r.entry_index = idx;
    r.entry_frame = fr;
    batch = {batch, r};
  endfunction

  function automatic void push_rand(logic [2:0] cmd);
    push_req(cmd, 20'($urandom), 6'($urandom), 8'($urandom));
  endfunction

  function automatic logic [19:0] pick_elapsed();
    int unsigned hi;
    hi = 2 * cur_period;
    if (hi > ELAPSED_MAX) hi = ELAPSED_MAX;
    case ($urandom_range(0, 9))
      0: return ELAPSED_MAX;
      1: return 20'($urandom);
      2: return '0;
      default: return 20'($urandom_range(0, hi));
    endcase
  endfunction

  task automatic send_batch();
    sfs_in_t r;
    int gap;
    while (batch.size() > 0) begin
      r = batch.pop_front();
      gap = burst ? 0 : $urandom_range(0, 8);
      if (gap > 0) begin
        req_ch.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      req_ch.valid <= 1'b1;
      req_ch.data <= r;
      @(posedge clk);
      while (!req_ch.ready) @(posedge clk);
      sb.accept_command(r);
      sent++;
    end
    req_ch.valid <= 1'b0;
  endtask

  task automatic wait_drained();
    while (sb.expected_frames.size() != 0) @(posedge clk);
    repeat (2) @(posedge clk);
  endtask

  task automatic cfg_write(logic [CIDX_W-1:0] idx, logic [CFG_W-1:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    sb.write_reg(idx, val);
  endtask

  task automatic configure(logic [1:0] m, logic lp, logic [7:0] rs, logic [7:0] re,
                           logic [19:0] per, logic [6:0] cl);
    cfg_write(CFG_LIST_MODE, 20'(m));
    cfg_write(CFG_LOOP_ENABLE, 20'(lp));
    cfg_write(CFG_RANGE_START, 20'(rs));
    cfg_write(CFG_RANGE_END, 20'(re));
    cfg_write(CFG_FRAME_PERIOD, per);
    cfg_write(CFG_CUSTOM_LEN, 20'(cl));
    cfg_we <= 1'b0;
    cur_period = per;
    @(posedge clk);
  endtask

  task automatic random_phase();
    logic [1:0]  m;
    logic        lp;
    logic [7:0]  rs;
    logic [7:0]  re;
    logic [19:0] per;
    logic [6:0]  cl;
    logic [5:0]  idx;
    int          n_ticks;
    bit          sat;
    m = 2'($urandom_range(0, 3));
    lp = 1'($urandom);
    rs = 8'($urandom);
    case ($urandom_range(0, 5))
      0: re = 8'($urandom);
      1: begin
        rs = 8'd0;
        re = 8'd255;
      end
      2: re = rs - 8'($urandom_range(1, 4));
      default: re = rs + 8'($urandom_range(0, 7));
    endcase
    case ($urandom_range(0, 9))
      0: per = '0;
      1: per = ELAPSED_MAX;
      2: per = 20'($urandom);
      default: per = 20'($urandom_range(1, 40));
    endcase
    case ($urandom_range(0, 7))
      0: cl = 7'd0;
      1: cl = 7'd64;
      2: cl = 7'($urandom);
      default: cl = 7'($urandom_range(1, 12));
    endcase
    // saturation run: tiny period, looping, full-scale ticks
    sat = ($urandom_range(0, 7) == 0);
    if (sat) begin
      per = 20'($urandom_range(0, 3));
      lp = 1'b1;
    end
    burst = ($urandom_range(0, 3) == 0);
    configure(m, lp, rs, re, per, cl);

    if (m == MODE_CUSTOM || $urandom_range(0, 3) == 0) begin
      for (int i = $urandom_range(2, 10); i > 0; i--) begin
        idx = ($urandom_range(0, 3) == 0) ? 6'($urandom) : 6'($urandom_range(0, 15));
        push_req(CMD_LOAD, 20'($urandom), idx, 8'($urandom));
      end
    end
    // resume keeps a stale position, which may sit past the new list end
    push_rand(($urandom_range(0, 3) == 0) ? CMD_RESUME : CMD_START);
    n_ticks = sat ? 24 : $urandom_range(15, 50);
    repeat (n_ticks) begin
      if ($urandom_range(0, 19) == 0) begin
        case ($urandom_range(0, 6))
          0: push_rand(CMD_START);
          1: push_rand(CMD_STOP);
          2: push_rand(CMD_PAUSE);
          3: push_rand(CMD_RESUME);
          4: push_rand(CMD_LOAD);
          5: push_rand(CMD_NOP_LO);
          default: push_rand(CMD_NOP_HI);
        endcase
      end else begin
        push_req(CMD_TICK, sat ? ELAPSED_MAX : pick_elapsed(), 6'($urandom), 8'($urandom));
      end
    end
  endtask

  initial begin : result_sink
    int stall;
    res_ch.ready <= 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      stall = burst ? 0 : $urandom_range(0, 8);
      if (stall > 0) begin
        res_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      res_ch.ready <= 1'b1;
      @(posedge clk);
      while (!res_ch.valid) @(posedge clk);
      sb.check_result(res_ch.data);
    end
  end

  initial begin : stimulus
    sb = new();
    rst_n <= 1'b0;
    cfg_we <= 1'b0;
    cfg_index <= '0;
    cfg_wdata <= '0;
    req_ch.valid <= 1'b0;
    req_ch.data <= '0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset settings: stopped ticks, no-op codes, single-frame list without loop
    push_rand(CMD_NOP_LO);
    push_req(CMD_TICK, ELAPSED_MAX, 6'd0, 8'd0);
    push_req(CMD_LOAD, 20'd0, 6'd63, 8'hFF);
    push_req(CMD_LOAD, ELAPSED_MAX, 6'd0, 8'h5A);
    push_rand(CMD_START);
    push_req(CMD_TICK, 20'd0, 6'd63, 8'hFF);
    push_req(CMD_TICK, 20'd1, 6'd0, 8'd0);
    push_rand(CMD_RESUME);
    push_rand(CMD_NOP_HI);
    send_batch();
    wait_drained();

    // zero period, full-width looping ping-pong
    configure(MODE_PING, 1'b1, 8'd0, 8'd255, 20'd0, 7'd64);
    push_rand(CMD_START);
    push_req(CMD_TICK, 20'd0, 6'd0, 8'd0);
    push_req(CMD_TICK, 20'd0, 6'd0, 8'd0);
    push_rand(CMD_PAUSE);
    push_req(CMD_TICK, ELAPSED_MAX, 6'd0, 8'd0);
    push_rand(CMD_RESUME);
    push_rand(CMD_STOP);
    send_batch();
    wait_drained();

    // unused mode code, end below start, largest period, oversize table length
    configure(MODE_FWD_ALIAS, 1'b0, 8'd200, 8'd100, ELAPSED_MAX, 7'd127);
    push_rand(CMD_START);
    push_req(CMD_TICK, ELAPSED_MAX, 6'd0, 8'd0);
    push_rand(CMD_START);
    push_req(CMD_TICK, ELAPSED_MAX - 20'd1, 6'd0, 8'd0);
    send_batch();
    wait_drained();

    configure(MODE_CUSTOM, 1'b0, 8'd255, 8'd0, 20'd1, 7'd64);
    push_rand(CMD_START);
    push_req(CMD_LOAD, 20'd0, 6'd1, 8'hFF);
    push_req(CMD_TICK, ELAPSED_MAX, 6'd0, 8'd0);
    send_batch();
    wait_drained();

    // position left past the end of a shorter list
    configure(MODE_FWD, 1'b1, 8'd0, 8'd0, 20'd1, 7'd1);
    push_rand(CMD_RESUME);
    push_req(CMD_TICK, ELAPSED_MAX, 6'd0, 8'd0);
    send_batch();

    while (sent < TARGET_REQS) begin
      wait_drained();
      random_phase();
      send_batch();
    end

    wait_drained();
    repeat (8) @(posedge clk);
    if (sb.errors == 0 && sb.expected_frames.size() == 0) begin
      $display("PASS sprite_frame_sequencer_unit");
    end else begin
      $display("FAIL sprite_frame_sequencer_unit");
    end
    $finish;
  end

endmodule

>>> filelist.f
hdl/sfs_pkg.sv
hdl/sfs_chan_if.sv
hdl/sprite_frame_sequencer_unit.sv
sim/sprite_frame_sequencer_unit_tb.sv
